// ----- hw/rtl/msb_pkg.sv -----
// Shared constants, codes and control structs for the multi-stack shared buffer.
// Used by msb_link_store, msb_top_table and multi_stack_shared_buffer_unit.
`default_nettype none

package msb_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int STACKS_DEF = 8;

  localparam int CMD_W  = 1;
  localparam int SID_W  = 3;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
  localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  // link/data store control
  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic data_we;
  } msb_lnk_ctl_t;

  // stack top table control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } msb_top_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/msb_link_store.sv -----
// Entry store: per-entry link and data memories with registered reads.
// Links at or above the fill count read as the initial chain (entry i -> i+1).
// Depends on msb_pkg.
`default_nettype none

module msb_link_store #(
  parameter int DEPTH = msb_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire msb_pkg::msb_lnk_ctl_t     ctl,
  input  wire logic [AW-1:0]             rd_addr,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [LW-1:0]             wr_link,
  input  wire logic [msb_pkg::VAL_W-1:0] wr_data,
  output logic      [LW-1:0]             rd_link,
  output logic      [msb_pkg::VAL_W-1:0] rd_data
);

  logic [LW-1:0]             link_mem [DEPTH];
  logic [msb_pkg::VAL_W-1:0] data_mem [DEPTH];

  logic [LW-1:0] link_q;
  logic [LW-1:0] next_q;
  logic          fresh_q;
  logic [LW-1:0] fill;

  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
    if (ctl.data_we) begin
      data_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      link_q  <= link_mem[rd_addr];
      rd_data <= data_mem[rd_addr];
      fresh_q <= (LW'(rd_addr) >= fill);
      next_q  <= LW'(rd_addr) + LW'(1);
    end
  end

  // Entries are first written in index order, so everything at or above
  // fill still holds its reset link.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.link_we && (LW'(wr_addr) == fill)) begin
      fill <= fill + LW'(1);
    end
  end

  assign rd_link = fresh_q ? next_q : link_q;

endmodule

`default_nettype wire

// ----- hw/rtl/msb_top_table.sv -----
// Stack top table: one top pointer per stack, registered read.
// Valid bits make an unwritten stack read as empty. Depends on msb_pkg.
`default_nettype none

module msb_top_table #(
  parameter int DEPTH  = msb_pkg::DEPTH_DEF,
  parameter int STACKS = msb_pkg::STACKS_DEF,
  parameter int TW     = (STACKS > 1) ? $clog2(STACKS) : 1,
  parameter int LW     = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire msb_pkg::msb_top_ctl_t ctl,
  input  wire logic [TW-1:0]         rd_idx,
  input  wire logic [TW-1:0]         wr_idx,
  input  wire logic [LW-1:0]         wr_val,
  output logic      [LW-1:0]         rd_top
);

  localparam logic [LW-1:0] NONE = LW'(DEPTH);

  logic [LW-1:0]     top_mem [STACKS];
  logic [STACKS-1:0] vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      top_mem[wr_idx] <= wr_val;
    end
    if (ctl.rd_en) begin
      rd_top <= vld[rd_idx] ? top_mem[rd_idx] : NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.wr_en) begin
      vld[wr_idx] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/multi_stack_shared_buffer_unit.sv -----
// Several LIFO stacks sharing one entry store, chained by a free list.
// Push: top-table and free-head link read in IDLE, then commit in TOP. Pop: the same
// reads, then a link/data read of the top entry in TOP and the commit in POP (an empty or
// bad stack commits in TOP). A new request is taken only in IDLE, and a commit waits while
// the previous result waits on out_ready. Reset: stack valid bits and the entry fill count
// clear at once, no clearing pass over the store.
`default_nettype none

module multi_stack_shared_buffer_unit #(
  parameter int DEPTH  = msb_pkg::DEPTH_DEF,
  parameter int STACKS = msb_pkg::STACKS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             command,
  input  wire logic [msb_pkg::SID_W-1:0]        stack_id,
  input  wire logic signed [msb_pkg::VAL_W-1:0] push_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [msb_pkg::VAL_W-1:0]      pop_value,
  output logic [msb_pkg::STAT_W-1:0]            status
);

  localparam int AW  = $clog2(DEPTH);
  localparam int LW  = $clog2(DEPTH + 1);
  localparam int TW  = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int SCW = 9;

  localparam logic [LW-1:0] NONE = LW'(DEPTH);

  typedef enum logic [1:0] {
    IDLE,
    TOP,
    POP
  } state_t;

  state_t state, state_next;

  logic [LW-1:0]             free_head, free_head_next;
  logic                      cmd_q;
  logic [TW-1:0]             sid_q;
  logic                      sid_ok_q;
  logic [msb_pkg::VAL_W-1:0] val_q;

  msb_pkg::msb_lnk_ctl_t     lnk_ctl;
  logic [AW-1:0]             lnk_rd_addr;
  logic [AW-1:0]             lnk_wr_addr;
  logic [LW-1:0]             lnk_wr_link;
  logic [LW-1:0]             lnk_rd_link;
  logic [msb_pkg::VAL_W-1:0] lnk_rd_data;

  msb_pkg::msb_top_ctl_t     top_ctl;
  logic [TW-1:0]             top_rd_idx;
  logic [LW-1:0]             top_wr_val;
  logic [LW-1:0]             top_rd;

  logic                      out_free;
  logic                      commit;
  logic [msb_pkg::VAL_W-1:0] res_value;
  logic [msb_pkg::STAT_W-1:0] res_status;
  logic                      accept;
  logic                      free_none;
  logic                      top_none;

  msb_link_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .LW    (LW)
  ) u_link_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (lnk_ctl),
    .rd_addr (lnk_rd_addr),
    .wr_addr (lnk_wr_addr),
    .wr_link (lnk_wr_link),
    .wr_data (val_q),
    .rd_link (lnk_rd_link),
    .rd_data (lnk_rd_data)
  );

  msb_top_table #(
    .DEPTH  (DEPTH),
    .STACKS (STACKS),
    .TW     (TW),
    .LW     (LW)
  ) u_top_table (
    .clk    (clk),
    .rst    (rst),
    .ctl    (top_ctl),
    .rd_idx (top_rd_idx),
    .wr_idx (sid_q),
    .wr_val (top_wr_val),
    .rd_top (top_rd)
  );

  assign in_ready  = (state == IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign free_none = (free_head >= NONE);
  assign top_none  = (top_rd >= NONE);

  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    lnk_ctl        = '0;
    top_ctl        = '0;
    lnk_rd_addr    = free_head[AW-1:0];
    lnk_wr_addr    = free_head[AW-1:0];
    lnk_wr_link    = top_rd;
    top_rd_idx     = TW'(stack_id);
    top_wr_val     = free_head;
    commit         = 1'b0;
    res_value      = '0;
    res_status     = msb_pkg::ST_OK;
    case (state)
      IDLE: begin
        if (in_valid) begin
          // fetch the stack top and the free head's link together
          lnk_ctl.rd_en = 1'b1;
          top_ctl.rd_en = 1'b1;
          state_next    = TOP;
        end
      end
      TOP: begin
        if (cmd_q == msb_pkg::CMD_PUSH) begin
          if (out_free) begin
            commit     = 1'b1;
            state_next = IDLE;
            if (!sid_ok_q || free_none) begin
              res_status = msb_pkg::ST_OVERFLOW;
            end else begin
              lnk_ctl.link_we = 1'b1;
              lnk_ctl.data_we = 1'b1;
              top_ctl.wr_en   = 1'b1;
              free_head_next  = lnk_rd_link;
            end
          end
        end else if (!sid_ok_q || top_none) begin
          if (out_free) begin
            commit     = 1'b1;
            res_status = msb_pkg::ST_UNDERFLOW;
            state_next = IDLE;
          end
        end else begin
          lnk_ctl.rd_en = 1'b1;
          lnk_rd_addr   = top_rd[AW-1:0];
          state_next    = POP;
        end
      end
      POP: begin
        if (out_free) begin
          commit          = 1'b1;
          res_value       = lnk_rd_data;
          top_ctl.wr_en   = 1'b1;
          top_wr_val      = lnk_rd_link;
          lnk_ctl.link_we = 1'b1;
          lnk_wr_addr     = top_rd[AW-1:0];
          lnk_wr_link     = free_head;
          free_head_next  = top_rd;
          state_next      = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        cmd_q    <= command;
        sid_q    <= TW'(stack_id);
        sid_ok_q <= (SCW'(stack_id) < SCW'(STACKS));
        val_q    <= push_value;
      end
      if (commit) begin
        pop_value <= res_value;
        status    <= res_status;
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/multi_stack_shared_buffer_unit_tb.sv -----
// Self-checking bench for multi_stack_shared_buffer_unit: push/pop requests on
// eight stacks sharing one entry store, checked against an in-bench stack model.
// Depends on msb_pkg and the unit RTL only.
`timescale 1ns / 100ps

module multi_stack_shared_buffer_unit_tb;

  localparam int DEPTH_N    = msb_pkg::DEPTH_DEF;
  localparam int STACKS_N   = msb_pkg::STACKS_DEF;
  localparam int QUIET_MAX  = 3000;
  localparam int HOLD_LEN   = 400;
  localparam int LOG_MAX    = 10;
  localparam logic [6:0] NO_ENTRY = 7'(DEPTH_N);

  typedef struct packed {
    logic                             op;
    logic [msb_pkg::SID_W-1:0]        sid;
    logic signed [msb_pkg::VAL_W-1:0] val;
  } stack_req_t;

  typedef struct packed {
    logic signed [msb_pkg::VAL_W-1:0] value;
    logic [msb_pkg::STAT_W-1:0]       stat;
  } stack_result_t;

  typedef enum int {FILL, DRAIN, MIXED, NARROW} phase_style_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             command = msb_pkg::CMD_PUSH;
  logic [msb_pkg::SID_W-1:0]        stack_id = '0;
  logic signed [msb_pkg::VAL_W-1:0] push_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [msb_pkg::VAL_W-1:0] pop_value;
  logic [msb_pkg::STAT_W-1:0]       status;

  // bench copy of the stack store
  logic [msb_pkg::VAL_W-1:0] store_word [DEPTH_N];
  logic [6:0]                store_next [DEPTH_N];
  logic [6:0]                top_of [STACKS_N];
  logic [6:0]                free_first;

  stack_req_t    req_backlog [$];
  stack_result_t due_results [$];
  stack_req_t    cur_req;

  logic req_taken = 1'b0;
  logic res_taken = 1'b0;
  logic send_lazy = 1'b1;
  logic recv_lazy = 1'b1;
  logic hold_off  = 1'b0;
  int   send_gap  = 0;
  int   recv_gap  = 0;
  int   req_count = 0;
  int   quiet_cycles = 0;
  int   fail_count = 0;

  multi_stack_shared_buffer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .stack_id  (stack_id),
    .push_value(push_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pop_value (pop_value),
    .status    (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic queue_req(input logic op, input int sid,
                           input logic [msb_pkg::VAL_W-1:0] val);
    stack_req_t r;
    r.op  = op;
    r.sid = sid[msb_pkg::SID_W-1:0];
    r.val = val;
    req_backlog.push_back(r);
  endtask

  // Apply one request to the bench store and queue the result it must produce.
  task automatic predict_stack_op(input stack_req_t r);
    stack_result_t res;
    logic [6:0]    e;
    res.value = '0;
    res.stat  = msb_pkg::ST_OK;
    if (r.op == msb_pkg::CMD_PUSH) begin
      if (int'(r.sid) >= STACKS_N || int'(free_first) >= DEPTH_N) begin
        res.stat = msb_pkg::ST_OVERFLOW;
      end else begin
        e = free_first;
        store_word[e] = r.val;
        free_first = store_next[e];
        store_next[e] = top_of[r.sid];
        top_of[r.sid] = e;
      end
    end else begin
      if (int'(r.sid) >= STACKS_N || int'(top_of[r.sid]) >= DEPTH_N) begin
        res.stat = msb_pkg::ST_UNDERFLOW;
      end else begin
        e = top_of[r.sid];
        top_of[r.sid] = store_next[e];
        store_next[e] = free_first;
        free_first = e;
        res.value = store_word[e];
      end
    end
    due_results.push_back(res);
  endtask

  task automatic note_fail(input string what, input stack_result_t want);
    fail_count++;
    if (fail_count <= LOG_MAX)
      $display("%0t: %s: expected value %0d status %0d, got value %0d status %0d",
               $time, what, want.value, want.stat, pop_value, status);
  endtask

  // request driver: changes inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (req_taken) begin
        req_taken = 1'b0;
        if ($urandom_range(0, 15) == 0) send_lazy = !send_lazy;
        send_gap = send_lazy ? $urandom_range(0, 5) : 0;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        cur_req = req_backlog.pop_front();
        command    <= cur_req.op;
        stack_id   <= cur_req.sid;
        push_value <= cur_req.val;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side ready
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (res_taken) begin
        res_taken = 1'b0;
        if ($urandom_range(0, 15) == 0) recv_lazy = !recv_lazy;
        recv_gap = recv_lazy ? $urandom_range(0, 5) : 0;
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: samples both handshakes on the rising edge
  always @(posedge clk) begin : monitor
    stack_result_t want;
    logic          moved;
    moved = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        res_taken = 1'b1;
        if (due_results.size() == 0) begin
          want = '0;
          note_fail("result with no request pending", want);
        end else begin
          want = due_results.pop_front();
          if (pop_value !== want.value || status !== want.stat)
            note_fail("stack result mismatch", want);
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        req_taken = 1'b1;
        req_count++;
        predict_stack_op('{command, stack_id, push_value});
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // long receiver stall so the unit backs up and drops in_ready
  initial begin
    wait (req_count >= 400);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    int                        i;
    int                        k;
    int                        span;
    int                        sid;
    logic                      op;
    logic [msb_pkg::VAL_W-1:0] val;
    phase_style_t              style;

    for (i = 0; i < DEPTH_N; i++) begin
      store_word[i] = '0;
      store_next[i] = (i == DEPTH_N - 1) ? NO_ENTRY : 7'(i + 1);
    end
    for (i = 0; i < STACKS_N; i++) top_of[i] = NO_ENTRY;
    free_first = '0;

    // directed: empty pops, extreme values, LIFO order on both end stacks
    queue_req(msb_pkg::CMD_POP, 0, '0);
    queue_req(msb_pkg::CMD_POP, 7, 32'hFFFF_FFFF);
    queue_req(msb_pkg::CMD_PUSH, 0, 32'h7FFF_FFFF);
    queue_req(msb_pkg::CMD_PUSH, 0, 32'h8000_0000);
    queue_req(msb_pkg::CMD_PUSH, 7, 32'hFFFF_FFFF);
    queue_req(msb_pkg::CMD_PUSH, 7, 32'h0000_0000);
    queue_req(msb_pkg::CMD_PUSH, 3, 32'hAAAA_AAAA);
    queue_req(msb_pkg::CMD_PUSH, 4, 32'h5555_5555);
    queue_req(msb_pkg::CMD_PUSH, 1, 32'h0000_0001);
    queue_req(msb_pkg::CMD_PUSH, 2, 32'h0000_0002);
    queue_req(msb_pkg::CMD_PUSH, 5, 32'hFFFF_FFFE);
    queue_req(msb_pkg::CMD_PUSH, 6, 32'h1234_5678);
    queue_req(msb_pkg::CMD_POP, 0, '0);
    queue_req(msb_pkg::CMD_POP, 0, '0);
    queue_req(msb_pkg::CMD_POP, 0, '0);
    queue_req(msb_pkg::CMD_POP, 7, '0);
    queue_req(msb_pkg::CMD_POP, 7, '0);
    for (i = 1; i < 7; i++) queue_req(msb_pkg::CMD_POP, i, '0);

    // random phases; fill phases push mostly to run the free list dry, drain phases pop mostly to empty stacks
    while (req_backlog.size() < 1850) begin
      span = $urandom_range(40, 180);
      style = phase_style_t'($urandom_range(0, 3));
      for (k = 0; k < span; k++) begin
        case (style)
          FILL:    op = ($urandom_range(0, 99) < 85) ? msb_pkg::CMD_PUSH : msb_pkg::CMD_POP;
          DRAIN:   op = ($urandom_range(0, 99) < 15) ? msb_pkg::CMD_PUSH : msb_pkg::CMD_POP;
          default: op = $urandom_range(0, 1) ? msb_pkg::CMD_POP : msb_pkg::CMD_PUSH;
        endcase
        sid = (style == NARROW) ? $urandom_range(0, 1) : $urandom_range(0, STACKS_N - 1);
        case ($urandom_range(0, 7))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = '0;
          3:       val = '1;
          default: val = $urandom;
        endcase
        queue_req(op, sid, val);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
